/* sv/segment_lcd_frame_writer_unit_macros.svh */
// Assertion helpers used by the RTL.
`ifndef SEGMENT_LCD_FRAME_WRITER_UNIT_MACROS_SVH
`define SEGMENT_LCD_FRAME_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLFW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLFW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/slfw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package slfw_pkg;

    typedef enum logic [2:0] {
        KIND_INIT   = 3'd0,
        KIND_FILL   = 3'd1,
        KIND_SINGLE = 3'd2,
        KIND_DIGITS = 3'd3,
        KIND_TIME   = 3'd4
    } kind_t;

    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_MODE_COMMAND   = 2'd1;

    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h70;
    localparam logic [7:0] MODE_COMMAND_RESET   = 8'hc9;
    localparam logic [7:0] DOT_ADD              = 8'h01;
    localparam logic [7:0] COLON_ADD            = 8'h01;
    localparam logic [5:0] CLAMP_LIMIT          = 6'd59;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] fill_value;
        logic [7:0] ram_address;
        logic [7:0] seg_first;
        logic [7:0] seg_second;
        logic [7:0] seg_third;
        logic [7:0] seg_fourth;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } cmd_t;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       last_byte;
    } beat_t;

    function automatic logic [5:0] clamp59(input logic [7:0] v);
        clamp59 = (v > {2'b00, CLAMP_LIMIT}) ? CLAMP_LIMIT : v[5:0];
    endfunction

    function automatic logic [3:0] tens_of(input logic [5:0] v);
        if (v >= 6'd50) begin
            tens_of = 4'd5;
        end else if (v >= 6'd40) begin
            tens_of = 4'd4;
        end else if (v >= 6'd30) begin
            tens_of = 4'd3;
        end else if (v >= 6'd20) begin
            tens_of = 4'd2;
        end else if (v >= 6'd10) begin
            tens_of = 4'd1;
        end else begin
            tens_of = 4'd0;
        end
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] t10;
        t10 = 6'({2'b00, tens_of(v)} * 6'd10);
        units_of = 4'(v - t10);
    endfunction

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        case (d)
            4'd0:    seg_pattern = 8'h7e;
            4'd1:    seg_pattern = 8'h12;
            4'd2:    seg_pattern = 8'hbc;
            4'd3:    seg_pattern = 8'hb6;
            4'd4:    seg_pattern = 8'hd2;
            4'd5:    seg_pattern = 8'he6;
            4'd6:    seg_pattern = 8'hee;
            4'd7:    seg_pattern = 8'h32;
            4'd8:    seg_pattern = 8'hfe;
            4'd9:    seg_pattern = 8'hf6;
            default: seg_pattern = 8'h00;
        endcase
    endfunction

endpackage

`default_nettype wire

/* sv/slfw_byte_gen.sv */
`timescale 1ns / 1ps
`default_nettype none

module slfw_byte_gen (
    input  wire slfw_pkg::cmd_t  cmd,
    input  wire logic [3:0]      idx,
    input  wire logic [7:0]      device_address,
    input  wire logic [7:0]      mode_command,
    output      slfw_pkg::beat_t beat
);
    import slfw_pkg::*;

    logic [5:0] min_c;
    logic [5:0] sec_c;
    logic [3:0] digit;
    logic [7:0] pattern;

    always_comb begin
        min_c = clamp59(cmd.minutes);
        sec_c = clamp59(cmd.seconds);
        case (idx)
            4'd0, 4'd1, 4'd2:   digit = tens_of(min_c);
            4'd3, 4'd4, 4'd5:   digit = units_of(min_c);
            4'd6, 4'd7, 4'd8:   digit = tens_of(sec_c);
            default:            digit = units_of(sec_c);
        endcase
        pattern = seg_pattern(digit);
    end

    always_comb begin
        beat = '0;
        case (cmd.kind)
            KIND_INIT: begin
                case (idx)
                    4'd0:    beat = '{device_address, 1'b1, 1'b0, 1'b0};
                    default: beat = '{mode_command, 1'b0, 1'b1, 1'b1};
                endcase
            end
            KIND_FILL: begin
                case (idx)
                    4'd0:    beat = '{device_address, 1'b1, 1'b0, 1'b0};
                    4'd1:    beat = '{8'h00, 1'b0, 1'b0, 1'b0};
                    4'd5:    beat = '{cmd.fill_value, 1'b0, 1'b1, 1'b1};
                    default: beat = '{cmd.fill_value, 1'b0, 1'b0, 1'b0};
                endcase
            end
            KIND_SINGLE: begin
                case (idx)
                    4'd0:    beat = '{device_address, 1'b1, 1'b0, 1'b0};
                    4'd1:    beat = '{cmd.ram_address, 1'b0, 1'b0, 1'b0};
                    default: beat = '{cmd.fill_value, 1'b0, 1'b1, 1'b1};
                endcase
            end
            KIND_DIGITS: begin
                case (idx)
                    4'd0:    beat = '{device_address, 1'b1, 1'b0, 1'b0};
                    4'd1:    beat = '{8'h00, 1'b0, 1'b0, 1'b0};
                    4'd2:    beat = '{cmd.seg_first + DOT_ADD, 1'b0, 1'b0, 1'b0};
                    4'd3:    beat = '{cmd.seg_second + DOT_ADD, 1'b0, 1'b0, 1'b0};
                    4'd4:    beat = '{cmd.seg_third + DOT_ADD, 1'b0, 1'b0, 1'b0};
                    default: beat = '{cmd.seg_fourth + COLON_ADD, 1'b0, 1'b1, 1'b1};
                endcase
            end
            KIND_TIME: begin
                case (idx)
                    4'd0, 4'd3, 4'd6, 4'd9:
                        beat = '{device_address, 1'b1, 1'b0, 1'b0};
                    4'd1:    beat = '{8'h00, 1'b0, 1'b0, 1'b0};
                    4'd4:    beat = '{8'h08, 1'b0, 1'b0, 1'b0};
                    4'd7:    beat = '{8'h10, 1'b0, 1'b0, 1'b0};
                    4'd10:   beat = '{8'h18, 1'b0, 1'b0, 1'b0};
                    4'd11:   beat = '{pattern + COLON_ADD, 1'b0, 1'b1, 1'b1};
                    default: beat = '{pattern, 1'b0, 1'b1, 1'b0};
                endcase
            end
            default: beat = '0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/segment_lcd_frame_writer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                    Handshake
// s_        in         slfw_pkg::cmd_t command    s_valid / s_ready
// m_        out        slfw_pkg::beat_t bus byte  m_valid / m_ready
// cfg_      in         8-bit register write       cfg_wr_en, no wait
//
// A command emits one byte per cycle while m_ready holds: 2, 6, 3, 6 or 12 bytes for
// init, fill, single, digits and time, set by the byte index counter that walks the
// held command. Unused kinds are accepted and produce nothing.
// The next command is accepted in the cycle its predecessor's last byte moves
// into the output register, so bytes leave back to back when m_ready stays high.
// Reset is synchronous on aresetn, returns both config registers to their defaults

module segment_lcd_frame_writer_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output      logic            s_ready,
    input  wire slfw_pkg::cmd_t  s_data,
    output      logic            m_valid,
    input  wire logic            m_ready,
    output      slfw_pkg::beat_t m_data,
    input  wire logic            cfg_wr_en,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [7:0]      cfg_wdata
);
    import slfw_pkg::*;

    `include "segment_lcd_frame_writer_unit_macros.svh"

    logic [7:0] dev_addr_reg, dev_addr_next;
    logic [7:0] mode_cmd_reg, mode_cmd_next;
    cmd_t       cmd_reg, cmd_next;
    logic       cmd_valid_reg, cmd_valid_next;
    logic [3:0] idx_reg, idx_next;
    beat_t      out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    beat_t      gen_beat;
    logic       load;
    logic       advance;
    logic       accept;
    logic       kind_ok;

    slfw_byte_gen u_gen (
        .cmd            (cmd_reg),
        .idx            (idx_reg),
        .device_address (dev_addr_reg),
        .mode_command   (mode_cmd_reg),
        .beat           (gen_beat)
    );

    always_comb begin
        load    = !out_valid_reg || m_ready;
        advance = load && cmd_valid_reg;
        s_ready = !cmd_valid_reg || (advance && gen_beat.last_byte);
        accept  = s_valid && s_ready;
        kind_ok = s_data.kind inside {KIND_INIT, KIND_FILL, KIND_SINGLE, KIND_DIGITS, KIND_TIME};
    end

    always_comb begin
        dev_addr_next = dev_addr_reg;
        mode_cmd_next = mode_cmd_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: dev_addr_next = cfg_wdata;
                REG_MODE_COMMAND:   mode_cmd_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        idx_next       = idx_reg;
        if (advance) begin
            if (gen_beat.last_byte) begin
                cmd_valid_next = 1'b0;
                idx_next       = '0;
            end else begin
                idx_next = idx_reg + 4'd1;
            end
        end
        if (accept) begin
            cmd_next       = s_data;
            cmd_valid_next = kind_ok;
            idx_next       = '0;
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = cmd_valid_reg;
            out_next       = gen_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg  <= DEVICE_ADDRESS_RESET;
            mode_cmd_reg  <= MODE_COMMAND_RESET;
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            dev_addr_reg  <= dev_addr_next;
            mode_cmd_reg  <= mode_cmd_next;
            cmd_valid_reg <= cmd_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `SLFW_ASSERT_NOW(a_idx_range, aclk, aresetn, cmd_valid_reg, idx_reg <= 4'd11, "byte index out of range")
    `SLFW_ASSERT_NOW(a_last_has_stop, aclk, aresetn, m_valid, !m_data.last_byte || m_data.stop_after, "last byte without stop")
    `SLFW_ASSERT_NEXT(a_restart, aclk, aresetn, m_valid && m_ready && m_data.stop_after && !m_data.last_byte, m_valid && m_data.start_before, "missing start after mid-command stop")
    `SLFW_ASSERT_NEXT(a_drain, aclk, aresetn, m_valid && m_ready && m_data.last_byte && !cmd_valid_reg, !m_valid, "byte emitted with no command held")

endmodule

`default_nettype wire
